/* hw/rtl/circumcircle_three_points_top_defines.svh */
// Assertion macros shared by the circumcircle checker.
`ifndef CIRCUMCIRCLE_THREE_POINTS_TOP_DEFINES_SVH
`define CIRCUMCIRCLE_THREE_POINTS_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define CIRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define CIRC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/circ_pkg.sv */
package circ_pkg;

  // Field and datapath widths.
  localparam int CoordW = 32;   // input and center coordinates
  localparam int DiffW  = 33;   // coordinate differences
  localparam int SqW    = 64;   // squared coordinates and their sums
  localparam int CaW    = 65;   // bisector constant terms
  localparam int ProdW  = 66;   // 33 x 33 products
  localparam int DetW   = 67;   // determinant
  localparam int NumW   = 100;  // Cramer numerators
  localparam int DenW   = 68;   // twice the determinant magnitude
  localparam int QuoW   = 32;   // quotient bits produced by the divider
  localparam int RadSW  = 66;   // squared radius
  localparam int RootW  = 33;   // square root
  localparam int SremW  = 35;   // square root remainder
  localparam int RadW   = 31;   // radius field

  // Pipeline depths.
  localparam int PrepLat   = 7;
  localparam int DivLat    = QuoW + 2;
  localparam int SqrtSteps = RadSW / 2;
  localparam int RadLat    = SqrtSteps + 4;
  localparam int TopLat    = PrepLat + DivLat + RadLat + 1;

  typedef enum logic [1:0] {
    FIT_OK        = 2'd0,
    FIT_COLLINEAR = 2'd1,
    FIT_SAT       = 2'd2
  } fit_status_t;

  // Data that rides along with an item through the divider and radius stages.
  typedef struct packed {
    logic                     collinear;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
  } side_t;

  typedef struct packed {
    logic            neg_x;
    logic            neg_y;
    logic [NumW-1:0] mag_x;
    logic [NumW-1:0] mag_y;
    logic [DenW-1:0] den;
    side_t           side;
  } div_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic                     sat;
    side_t                    side;
  } center_t;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [RadW-1:0]   radius;
    logic              sat;
    logic              collinear;
  } circle_t;

endpackage

/* hw/rtl/circumcircle_three_points_top.sv */
// Circle through three points in signed Q16.16. A point triple is taken at
// every clock edge where start is high and busy is low; busy is high during
// reset and up to the first clock edge after it, so the block then takes one
// triple per cycle. Each result appears for one cycle with out_valid high, in
// the order the triples came in. Most of the depth comes from the 32 one-bit
// stages of the center divider and the 33 one-bit stages of the radius square
// root.
// There is no way to hold a result back: a receiver must take every cycle in
// which out_valid is high. Collinear or coincident points give a zero circle
// with status collinear; a center or radius beyond range is clamped and
// flagged as saturated.
module circumcircle_three_points_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [circ_pkg::CoordW-1:0] in_first_x,
  input  logic signed [circ_pkg::CoordW-1:0] in_first_y,
  input  logic signed [circ_pkg::CoordW-1:0] in_second_x,
  input  logic signed [circ_pkg::CoordW-1:0] in_second_y,
  input  logic signed [circ_pkg::CoordW-1:0] in_third_x,
  input  logic signed [circ_pkg::CoordW-1:0] in_third_y,
  output logic                               out_valid,
  output logic signed [circ_pkg::CoordW-1:0] out_center_x,
  output logic signed [circ_pkg::CoordW-1:0] out_center_y,
  output logic        [circ_pkg::RadW-1:0]   out_radius,
  output logic        [1:0]                  out_fit_status
);
  import circ_pkg::*;

  logic    busy_r;
  logic    in_valid;
  logic    prep_valid, div_valid, rad_valid;
  div_in_t prep_data;
  center_t div_data;
  circle_t rad_data;

  // Busy only while coming out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign in_valid = start & ~busy_r;

  circ_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .first_x   (in_first_x),
    .first_y   (in_first_y),
    .second_x  (in_second_x),
    .second_y  (in_second_y),
    .third_x   (in_third_x),
    .third_y   (in_third_y),
    .out_valid (prep_valid),
    .out_data  (prep_data)
  );

  circ_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_data   (prep_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  circ_rad u_rad (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .out_valid (rad_valid),
    .out_data  (rad_data)
  );

  // Output register: collinear items are forced to a zero circle.
  logic                     out_valid_r;
  logic signed [CoordW-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [RadW-1:0]          rad_r, rad_nxt;
  fit_status_t              fit_r, fit_nxt;

  always_comb begin
    if (rad_data.collinear) begin
      cx_nxt  = '0;
      cy_nxt  = '0;
      rad_nxt = '0;
      fit_nxt = FIT_COLLINEAR;
    end else begin
      cx_nxt  = $signed(rad_data.cx);
      cy_nxt  = $signed(rad_data.cy);
      rad_nxt = rad_data.radius;
      fit_nxt = rad_data.sat ? FIT_SAT : FIT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rad_valid;
    end
  end

  always_ff @(posedge clk) begin
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    rad_r <= rad_nxt;
    fit_r <= fit_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_center_x   = cx_r;
  assign out_center_y   = cy_r;
  assign out_radius     = rad_r;
  assign out_fit_status = fit_r;

endmodule

/* hw/rtl/circ_prep.sv */
module circ_prep (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [circ_pkg::CoordW-1:0] first_x,
  input  logic signed [circ_pkg::CoordW-1:0] first_y,
  input  logic signed [circ_pkg::CoordW-1:0] second_x,
  input  logic signed [circ_pkg::CoordW-1:0] second_y,
  input  logic signed [circ_pkg::CoordW-1:0] third_x,
  input  logic signed [circ_pkg::CoordW-1:0] third_y,
  output logic                               out_valid,
  output circ_pkg::div_in_t                  out_data
);
  import circ_pkg::*;

  localparam int SplitW = 32;

  // Stage 1: edge vectors and squared coordinates.
  logic v1_r;
  logic signed [DiffW-1:0] ax1_r, ay1_r, bx1_r, by1_r;
  logic signed [DiffW-1:0] ax1_nxt, ay1_nxt, bx1_nxt, by1_nxt;
  logic signed [SqW-1:0] sx1_r, sy1_r, sx2_r, sy2_r, sx3_r, sy3_r;
  logic signed [SqW-1:0] sx1_nxt, sy1_nxt, sx2_nxt, sy2_nxt, sx3_nxt, sy3_nxt;
  logic signed [CoordW-1:0] px1_r, py1_r;

  always_comb begin
    ax1_nxt = DiffW'(second_x) - DiffW'(first_x);
    ay1_nxt = DiffW'(second_y) - DiffW'(first_y);
    bx1_nxt = DiffW'(third_x) - DiffW'(second_x);
    by1_nxt = DiffW'(third_y) - DiffW'(second_y);
    sx1_nxt = SqW'(first_x) * SqW'(first_x);
    sy1_nxt = SqW'(first_y) * SqW'(first_y);
    sx2_nxt = SqW'(second_x) * SqW'(second_x);
    sy2_nxt = SqW'(second_y) * SqW'(second_y);
    sx3_nxt = SqW'(third_x) * SqW'(third_x);
    sy3_nxt = SqW'(third_y) * SqW'(third_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ax1_r <= ax1_nxt;
    ay1_r <= ay1_nxt;
    bx1_r <= bx1_nxt;
    by1_r <= by1_nxt;
    sx1_r <= sx1_nxt;
    sy1_r <= sy1_nxt;
    sx2_r <= sx2_nxt;
    sy2_r <= sy2_nxt;
    sx3_r <= sx3_nxt;
    sy3_r <= sy3_nxt;
    px1_r <= first_x;
    py1_r <= first_y;
  end

  // Stage 2: squared norms and the two determinant products.
  logic v2_r;
  logic [SqW-1:0] m1_r, m2_r, m3_r, m1_nxt, m2_nxt, m3_nxt;
  logic signed [ProdW-1:0] pab2_r, pba2_r, pab2_nxt, pba2_nxt;
  logic signed [DiffW-1:0] ax2_r, ay2_r, bx2_r, by2_r;
  logic signed [CoordW-1:0] px2_r, py2_r;

  always_comb begin
    m1_nxt   = sx1_r + sy1_r;
    m2_nxt   = sx2_r + sy2_r;
    m3_nxt   = sx3_r + sy3_r;
    pab2_nxt = ProdW'(ax1_r) * ProdW'(by1_r);
    pba2_nxt = ProdW'(ay1_r) * ProdW'(bx1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_r   <= m1_nxt;
    m2_r   <= m2_nxt;
    m3_r   <= m3_nxt;
    pab2_r <= pab2_nxt;
    pba2_r <= pba2_nxt;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    bx2_r  <= bx1_r;
    by2_r  <= by1_r;
    px2_r  <= px1_r;
    py2_r  <= py1_r;
  end

  // Stage 3: bisector constant terms and the determinant.
  logic v3_r;
  logic signed [CaW-1:0] ca3_r, cb3_r, ca3_nxt, cb3_nxt;
  logic signed [DetW-1:0] det3_r, det3_nxt;
  logic signed [DiffW-1:0] ax3_r, ay3_r, bx3_r, by3_r;
  logic signed [CoordW-1:0] px3_r, py3_r;

  always_comb begin
    ca3_nxt  = $signed(CaW'(m2_r) - CaW'(m1_r));
    cb3_nxt  = $signed(CaW'(m3_r) - CaW'(m2_r));
    det3_nxt = DetW'(pab2_r) - DetW'(pba2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ca3_r  <= ca3_nxt;
    cb3_r  <= cb3_nxt;
    det3_r <= det3_nxt;
    ax3_r  <= ax2_r;
    ay3_r  <= ay2_r;
    bx3_r  <= bx2_r;
    by3_r  <= by2_r;
    px3_r  <= px2_r;
    py3_r  <= py2_r;
  end

  // Stage 4: partial products, each constant term split into low and high halves.
  logic v4_r;
  logic signed [DiffW-1:0] cal, cah, cbl, cbh;
  logic signed [ProdW-1:0] cal_by_r, cah_by_r, cbl_ay_r, cbh_ay_r;
  logic signed [ProdW-1:0] cbl_ax_r, cbh_ax_r, cal_bx_r, cah_bx_r;
  logic signed [ProdW-1:0] cal_by_nxt, cah_by_nxt, cbl_ay_nxt, cbh_ay_nxt;
  logic signed [ProdW-1:0] cbl_ax_nxt, cbh_ax_nxt, cal_bx_nxt, cah_bx_nxt;
  logic signed [DetW-1:0] det4_r;
  logic signed [CoordW-1:0] px4_r, py4_r;

  always_comb begin
    cal = $signed({1'b0, ca3_r[SplitW-1:0]});
    cah = $signed(ca3_r[CaW-1:SplitW]);
    cbl = $signed({1'b0, cb3_r[SplitW-1:0]});
    cbh = $signed(cb3_r[CaW-1:SplitW]);
    cal_by_nxt = ProdW'(cal) * ProdW'(by3_r);
    cah_by_nxt = ProdW'(cah) * ProdW'(by3_r);
    cbl_ay_nxt = ProdW'(cbl) * ProdW'(ay3_r);
    cbh_ay_nxt = ProdW'(cbh) * ProdW'(ay3_r);
    cbl_ax_nxt = ProdW'(cbl) * ProdW'(ax3_r);
    cbh_ax_nxt = ProdW'(cbh) * ProdW'(ax3_r);
    cal_bx_nxt = ProdW'(cal) * ProdW'(bx3_r);
    cah_bx_nxt = ProdW'(cah) * ProdW'(bx3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    cal_by_r <= cal_by_nxt;
    cah_by_r <= cah_by_nxt;
    cbl_ay_r <= cbl_ay_nxt;
    cbh_ay_r <= cbh_ay_nxt;
    cbl_ax_r <= cbl_ax_nxt;
    cbh_ax_r <= cbh_ax_nxt;
    cal_bx_r <= cal_bx_nxt;
    cah_bx_r <= cah_bx_nxt;
    det4_r   <= det3_r;
    px4_r    <= px3_r;
    py4_r    <= py3_r;
  end

  // Stage 5: recombine the halves into full products.
  logic v5_r;
  logic signed [NumW-1:0] caby_r, cbay_r, axcb_r, bxca_r;
  logic signed [NumW-1:0] caby_nxt, cbay_nxt, axcb_nxt, bxca_nxt;
  logic signed [DetW-1:0] det5_r;
  logic signed [CoordW-1:0] px5_r, py5_r;

  always_comb begin
    caby_nxt = (NumW'(cah_by_r) <<< SplitW) + NumW'(cal_by_r);
    cbay_nxt = (NumW'(cbh_ay_r) <<< SplitW) + NumW'(cbl_ay_r);
    axcb_nxt = (NumW'(cbh_ax_r) <<< SplitW) + NumW'(cbl_ax_r);
    bxca_nxt = (NumW'(cah_bx_r) <<< SplitW) + NumW'(cal_bx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    caby_r <= caby_nxt;
    cbay_r <= cbay_nxt;
    axcb_r <= axcb_nxt;
    bxca_r <= bxca_nxt;
    det5_r <= det4_r;
    px5_r  <= px4_r;
    py5_r  <= py4_r;
  end

  // Stage 6: Cramer numerators.
  logic v6_r;
  logic signed [NumW-1:0] nx6_r, ny6_r, nx6_nxt, ny6_nxt;
  logic signed [DetW-1:0] det6_r;
  logic signed [CoordW-1:0] px6_r, py6_r;
  logic signed [DetW-1:0] det6_nxt_hold;

  assign det6_nxt_hold = det5_r;

  always_comb begin
    nx6_nxt = caby_r - cbay_r;
    ny6_nxt = axcb_r - bxca_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    nx6_r  <= nx6_nxt;
    ny6_r  <= ny6_nxt;
    det6_r <= det6_nxt_hold;
    px6_r  <= px5_r;
    py6_r  <= py5_r;
  end

  // Stage 7: sign and magnitude split; the denominator is twice |det|.
  logic v7_r;
  div_in_t d7_r, d7_nxt;
  logic [DetW-1:0] abs_det;

  always_comb begin
    abs_det             = det6_r[DetW-1] ? DetW'(-det6_r) : DetW'(det6_r);
    d7_nxt.neg_x        = nx6_r[NumW-1] ^ det6_r[DetW-1];
    d7_nxt.neg_y        = ny6_r[NumW-1] ^ det6_r[DetW-1];
    d7_nxt.mag_x        = nx6_r[NumW-1] ? NumW'(-nx6_r) : NumW'(nx6_r);
    d7_nxt.mag_y        = ny6_r[NumW-1] ? NumW'(-ny6_r) : NumW'(ny6_r);
    d7_nxt.den          = DenW'(abs_det) << 1;
    d7_nxt.side.collinear = (det6_r == '0);
    d7_nxt.side.x1      = px6_r;
    d7_nxt.side.y1      = py6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    d7_r <= d7_nxt;
  end

  assign out_valid = v7_r;
  assign out_data  = d7_r;

endmodule

/* hw/rtl/circ_div.sv */
module circ_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  circ_pkg::div_in_t in_data,
  output logic              out_valid,
  output circ_pkg::center_t out_data
);
  import circ_pkg::*;

  // One restoring step per stage for both coordinates; den is shared.
  typedef struct packed {
    logic [DenW-1:0] rem_x;
    logic [DenW-1:0] rem_y;
    logic [QuoW-1:0] q_x;
    logic [QuoW-1:0] q_y;
    logic [QuoW-1:0] lo_x;
    logic [QuoW-1:0] lo_y;
    logic [DenW-1:0] den;
    logic            ovf_x;
    logic            ovf_y;
    logic            neg_x;
    logic            neg_y;
    side_t           side;
  } div_stage_t;

  div_stage_t stg_r [QuoW+1];
  logic       vld_r [QuoW+1];
  div_stage_t stg0_nxt;

  // Rounds half away from zero and clamps to the signed coordinate range.
  function automatic logic [CoordW:0] round_sat(input logic [DenW-1:0] rem,
                                                input logic [QuoW-1:0] quo,
                                                input logic [DenW-1:0] den,
                                                input logic ovf,
                                                input logic neg);
    logic [QuoW:0]     q1;
    logic [QuoW:0]     negq;
    logic              up;
    logic              sat;
    logic [CoordW-1:0] val;
    up   = ({rem, 1'b0} >= {1'b0, den});
    q1   = {1'b0, quo} + {{QuoW{1'b0}}, up};
    negq = -q1;
    if (neg) begin
      sat = ovf || (q1 > {2'b01, {(QuoW-1){1'b0}}});
      val = sat ? {1'b1, {(CoordW-1){1'b0}}} : negq[CoordW-1:0];
    end else begin
      sat = ovf || (q1 > {2'b00, {(QuoW-1){1'b1}}});
      val = sat ? {1'b0, {(CoordW-1){1'b1}}} : q1[CoordW-1:0];
    end
    return {sat, val};
  endfunction

  // Entry stage: overflow test against den * 2^32 and the top remainder.
  always_comb begin
    stg0_nxt.rem_x = DenW'(in_data.mag_x >> QuoW);
    stg0_nxt.rem_y = DenW'(in_data.mag_y >> QuoW);
    stg0_nxt.q_x   = '0;
    stg0_nxt.q_y   = '0;
    stg0_nxt.lo_x  = in_data.mag_x[QuoW-1:0];
    stg0_nxt.lo_y  = in_data.mag_y[QuoW-1:0];
    stg0_nxt.den   = in_data.den;
    stg0_nxt.ovf_x = ((NumW+1)'(in_data.mag_x) >= ((NumW+1)'(in_data.den) << QuoW));
    stg0_nxt.ovf_y = ((NumW+1)'(in_data.mag_y) >= ((NumW+1)'(in_data.den) << QuoW));
    stg0_nxt.neg_x = in_data.neg_x;
    stg0_nxt.neg_y = in_data.neg_y;
    stg0_nxt.side  = in_data.side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= stg0_nxt;
  end

  // Quotient stages, most significant bit first.
  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    div_stage_t      step_nxt;
    logic [DenW:0]   tx;
    logic [DenW:0]   ty;

    always_comb begin
      tx       = {stg_r[k-1].rem_x, stg_r[k-1].lo_x[QuoW-1]};
      ty       = {stg_r[k-1].rem_y, stg_r[k-1].lo_y[QuoW-1]};
      step_nxt = stg_r[k-1];
      step_nxt.lo_x = stg_r[k-1].lo_x << 1;
      step_nxt.lo_y = stg_r[k-1].lo_y << 1;
      if (tx >= {1'b0, stg_r[k-1].den}) begin
        step_nxt.rem_x = DenW'(tx - {1'b0, stg_r[k-1].den});
        step_nxt.q_x   = {stg_r[k-1].q_x[QuoW-2:0], 1'b1};
      end else begin
        step_nxt.rem_x = tx[DenW-1:0];
        step_nxt.q_x   = {stg_r[k-1].q_x[QuoW-2:0], 1'b0};
      end
      if (ty >= {1'b0, stg_r[k-1].den}) begin
        step_nxt.rem_y = DenW'(ty - {1'b0, stg_r[k-1].den});
        step_nxt.q_y   = {stg_r[k-1].q_y[QuoW-2:0], 1'b1};
      end else begin
        step_nxt.rem_y = ty[DenW-1:0];
        step_nxt.q_y   = {stg_r[k-1].q_y[QuoW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= step_nxt;
    end
  end

  // Final stage: rounding and saturation.
  logic          vo_r;
  center_t       cen_r, cen_nxt;
  logic [CoordW:0] rx, ry;

  always_comb begin
    rx = round_sat(stg_r[QuoW].rem_x, stg_r[QuoW].q_x, stg_r[QuoW].den,
                   stg_r[QuoW].ovf_x, stg_r[QuoW].neg_x);
    ry = round_sat(stg_r[QuoW].rem_y, stg_r[QuoW].q_y, stg_r[QuoW].den,
                   stg_r[QuoW].ovf_y, stg_r[QuoW].neg_y);
    cen_nxt.cx   = $signed(rx[CoordW-1:0]);
    cen_nxt.cy   = $signed(ry[CoordW-1:0]);
    cen_nxt.sat  = rx[CoordW] | ry[CoordW];
    cen_nxt.side = stg_r[QuoW].side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vld_r[QuoW];
    end
  end

  always_ff @(posedge clk) begin
    cen_r <= cen_nxt;
  end

  assign out_valid = vo_r;
  assign out_data  = cen_r;

endmodule

/* hw/rtl/circ_rad.sv */
module circ_rad (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  circ_pkg::center_t in_data,
  output logic              out_valid,
  output circ_pkg::circle_t out_data
);
  import circ_pkg::*;

  typedef struct packed {
    logic [RadSW-1:0]  s;
    logic [SremW-1:0]  rem;
    logic [RootW-1:0]  root;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic              sat;
    logic              collinear;
  } sqrt_stage_t;

  // Stage R0: offsets from the center to the first point.
  logic v0_r;
  logic signed [DiffW-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  center_t c0_r;

  always_comb begin
    dx_nxt = DiffW'(in_data.cx) - DiffW'(in_data.side.x1);
    dy_nxt = DiffW'(in_data.cy) - DiffW'(in_data.side.y1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    c0_r <= in_data;
  end

  // Stage R1: squares of the offsets.
  logic v1_r;
  logic signed [ProdW-1:0] dx2_r, dy2_r, dx2_nxt, dy2_nxt;
  center_t c1_r;

  always_comb begin
    dx2_nxt = ProdW'(dx_r) * ProdW'(dx_r);
    dy2_nxt = ProdW'(dy_r) * ProdW'(dy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    dx2_r <= dx2_nxt;
    dy2_r <= dy2_nxt;
    c1_r  <= c0_r;
  end

  // Stage R2: squared radius seeds the square root pipeline.
  sqrt_stage_t stg_r [SqrtSteps+1];
  logic        vld_r [SqrtSteps+1];
  sqrt_stage_t stg0_nxt;

  always_comb begin
    stg0_nxt.s         = RadSW'(dx2_r) + RadSW'(dy2_r);
    stg0_nxt.rem       = '0;
    stg0_nxt.root      = '0;
    stg0_nxt.cx        = c1_r.cx;
    stg0_nxt.cy        = c1_r.cy;
    stg0_nxt.sat       = c1_r.sat;
    stg0_nxt.collinear = c1_r.side.collinear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= stg0_nxt;
  end

  // Digit recurrence: one root bit per stage from a pair of radicand bits.
  for (genvar k = 1; k <= SqrtSteps; k++) begin : g_step
    sqrt_stage_t       step_nxt;
    logic [SremW+1:0]  t;
    logic [SremW+1:0]  trial;

    always_comb begin
      t        = {stg_r[k-1].rem, stg_r[k-1].s[RadSW-1 -: 2]};
      trial    = {{(SremW-RootW){1'b0}}, stg_r[k-1].root, 2'b01};
      step_nxt = stg_r[k-1];
      step_nxt.s = stg_r[k-1].s << 2;
      if (t >= trial) begin
        step_nxt.rem  = SremW'(t - trial);
        step_nxt.root = {stg_r[k-1].root[RootW-2:0], 1'b1};
      end else begin
        step_nxt.rem  = t[SremW-1:0];
        step_nxt.root = {stg_r[k-1].root[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= step_nxt;
    end
  end

  // Final stage: round the root to nearest and clamp the radius.
  logic          vo_r;
  circle_t       cir_r, cir_nxt;
  logic [RootW:0] r1;
  logic          rad_sat;

  always_comb begin
    r1 = {1'b0, stg_r[SqrtSteps].root}
       + {{RootW{1'b0}}, (stg_r[SqrtSteps].rem > SremW'(stg_r[SqrtSteps].root))};
    rad_sat           = (r1[RootW:RadW] != '0);
    cir_nxt.cx        = stg_r[SqrtSteps].cx;
    cir_nxt.cy        = stg_r[SqrtSteps].cy;
    cir_nxt.radius    = rad_sat ? {RadW{1'b1}} : r1[RadW-1:0];
    cir_nxt.sat       = stg_r[SqrtSteps].sat | rad_sat;
    cir_nxt.collinear = stg_r[SqrtSteps].collinear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vld_r[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    cir_r <= cir_nxt;
  end

  assign out_valid = vo_r;
  assign out_data  = cir_r;

endmodule

/* hw/rtl/circ_checker.sv */
`include "circumcircle_three_points_top_defines.svh"

module circ_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic signed [circ_pkg::CoordW-1:0] out_center_x,
  input logic signed [circ_pkg::CoordW-1:0] out_center_y,
  input logic        [circ_pkg::RadW-1:0]   out_radius,
  input logic        [1:0]                  out_fit_status
);
  import circ_pkg::*;

  // Every result stems from an item that the block took in earlier.
  `CIRC_ASSERT_IMP(a_result_has_item, out_valid, $past(start && !busy, TopLat), "result without item")

  // A collinear result is the zero circle.
  `CIRC_ASSERT_IMP(a_collinear_zero, out_valid && (out_fit_status == FIT_COLLINEAR), (out_center_x == '0) && (out_center_y == '0) && (out_radius == '0), "collinear result not zero")

  // Status codes stay within the defined set.
  `CIRC_ASSERT_IMP(a_status_code, out_valid, (out_fit_status == FIT_OK) || (out_fit_status == FIT_COLLINEAR) || (out_fit_status == FIT_SAT), "bad status code")

  // Right after reset the pipeline is empty.
  `CIRC_ASSERT_NXT(a_empty_after_reset, busy, !out_valid, "result right after reset")

endmodule

bind circumcircle_three_points_top circ_checker u_circ_checker (.*);

/* bench/tb.sv */
module tb;
  import circ_pkg::*;

  typedef logic signed [159:0] wide_t;

  // One expected circle, in the order the items were accepted.
  typedef struct {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        rad;
    fit_status_t        status;
  } circle_exp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_first_x = '0, in_first_y = '0;
  logic signed [31:0] in_second_x = '0, in_second_y = '0;
  logic signed [31:0] in_third_x = '0, in_third_y = '0;
  logic out_valid;
  logic signed [31:0] out_center_x, out_center_y;
  logic [30:0] out_radius;
  logic [1:0] out_fit_status;

  circle_exp_t pending_circles[$];
  int mismatch_count = 0;
  int idle_pct = 0;

  circumcircle_three_points_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_third_x(in_third_x), .in_third_y(in_third_y),
    .out_valid(out_valid), .out_center_x(out_center_x),
    .out_center_y(out_center_y), .out_radius(out_radius),
    .out_fit_status(out_fit_status)
  );

  always #2 clk = ~clk;

  // Rounded quotient of num by a positive den, clamped to the signed 32-bit range.
  function automatic logic signed [31:0] round_div_clamp(wide_t num, wide_t den,
                                                         ref logic sat);
    wide_t mag, q, r;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    r = mag % den;
    if (2 * r >= den) q = q + 1;
    if (num < 0) begin
      if (q > 160'sh80000000) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return -q[31:0];
    end
    if (q > 160'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    return q[31:0];
  endfunction

  // Square root rounded to nearest.
  function automatic wide_t round_sqrt(wide_t s);
    wide_t root, t;
    root = 0;
    for (int i = 34; i >= 0; i--) begin
      t = root | (wide_t'(1) <<< i);
      if (t * t <= s) root = t;
    end
    if (s - root * root > root) root = root + 1;
    return root;
  endfunction

  // Circle through three points: bisector intersection by Cramer's rule.
  function automatic circle_exp_t circumcircle(logic signed [31:0] x1, y1, x2, y2,
                                               x3, y3);
    circle_exp_t c;
    wide_t ax, ay, bx, by, ca, cb, det, nx, ny, dx, dy, rad;
    logic sat;
    sat = 1'b0;
    ax = wide_t'(x2) - wide_t'(x1);
    ay = wide_t'(y2) - wide_t'(y1);
    bx = wide_t'(x3) - wide_t'(x2);
    by = wide_t'(y3) - wide_t'(y2);
    ca = wide_t'(x2) * x2 + wide_t'(y2) * y2 - wide_t'(x1) * x1 - wide_t'(y1) * y1;
    cb = wide_t'(x3) * x3 + wide_t'(y3) * y3 - wide_t'(x2) * x2 - wide_t'(y2) * y2;
    det = ax * by - ay * bx;
    if (det == 0) begin
      c.cx = '0;
      c.cy = '0;
      c.rad = '0;
      c.status = FIT_COLLINEAR;
      return c;
    end
    nx = ca * by - cb * ay;
    ny = ax * cb - bx * ca;
    if (det < 0) begin
      det = -det;
      nx = -nx;
      ny = -ny;
    end
    c.cx = round_div_clamp(nx, 2 * det, sat);
    c.cy = round_div_clamp(ny, 2 * det, sat);
    dx = wide_t'(c.cx) - wide_t'(x1);
    dy = wide_t'(c.cy) - wide_t'(y1);
    rad = round_sqrt(dx * dx + dy * dy);
    if (rad > 160'sh7FFFFFFF) begin
      rad = 160'sh7FFFFFFF;
      sat = 1'b1;
    end
    c.rad = rad[30:0];
    c.status = sat ? FIT_SAT : FIT_OK;
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Send one item; start stays high while items follow back to back.
  // Each following cycle is idle with a chance of idle_pct in a hundred.
  task automatic send_triple(logic signed [31:0] x1, y1, x2, y2, x3, y3);
    @(negedge clk);
    start = 1'b1;
    in_first_x = x1; in_first_y = y1;
    in_second_x = x2; in_second_y = y2;
    in_third_x = x3; in_third_y = y3;
    do @(posedge clk); while (busy);
    pending_circles.push_back(circumcircle(x1, y1, x2, y2, x3, y3));
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      in_first_x = $urandom;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_circles.size() != 0) @(posedge clk);
  endtask

  // Each result is compared with the oldest expected circle.
  always @(posedge clk) begin
    circle_exp_t e;
    if (rst_n && out_valid) begin
      if (pending_circles.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        e = pending_circles.pop_front();
        if (out_center_x !== e.cx) report_mismatch("center_x", out_center_x, e.cx);
        if (out_center_y !== e.cy) report_mismatch("center_y", out_center_y, e.cy);
        if (out_radius !== e.rad) report_mismatch("radius", out_radius, e.rad);
        if (out_fit_status !== e.status)
          report_mismatch("fit_status", out_fit_status, e.status);
      end
    end
  end

  // Extremes, coincident and collinear points, overflow of center and radius.
  task automatic test_directed();
    idle_pct = 0;
    send_triple(0, 0, 32'sh10000, 0, 0, 32'sh10000);
    send_triple(0, 0, 0, 0, 0, 0);
    send_triple(5, 7, 5, 7, 100, -3);
    send_triple(0, 0, 10, 10, 20, 20);
    send_triple(-100, 50, -100, 60, -100, 70);
    send_triple(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh80000000, 32'sh7FFFFFFF);
    send_triple(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh80000000);
    send_triple(32'sh80000000, 0, 32'sh7FFFFFFF, 0, 0, 1);
    send_triple(0, 0, 1, 0, 2, 1);
    send_triple(0, 0, 1000000, 0, 2000000, 1);
    send_triple(-1, -1, 1, 1, -1, 1);
    send_triple(32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0);
    send_triple(1, 0, 0, 1, -1, 0);
    send_triple(3, 1, 1, 3, 2, 2);
    send_triple(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_triple(-32'sh40000, 32'sh30000, 32'sh50000, -32'sh20000, 7, 32'sh12345);
    hold_until_drained();
  endtask

  // Random triples: full range, small coordinates and nearly collinear ones.
  task automatic test_random(int count, int pct);
    logic signed [31:0] p[6];
    int kind;
    int k;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(3);
      for (int i = 0; i < 6; i++) p[i] = $urandom;
      if (kind == 1) begin
        for (int i = 0; i < 6; i++) p[i] = $signed($urandom_range(16)) - 8;
      end else if (kind == 2) begin
        for (int i = 0; i < 4; i++) p[i] = p[i] >>> $urandom_range(24, 4);
        k = $signed($urandom_range(6)) - 3;
        p[4] = p[0] + k * (p[2] - p[0]) + $signed($urandom_range(2)) - 1;
        p[5] = p[1] + k * (p[3] - p[1]) + $signed($urandom_range(2)) - 1;
      end
      send_triple(p[0], p[1], p[2], p[3], p[4], p[5]);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(500, 0);
    test_random(500, 79);
    hold_until_drained();
    test_random(600, 6);
    hold_until_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
